// ----- sv/tilt_compensated_compass_angles_unit_macros.svh -----
// assertion macros shared by the compass angle unit
`ifndef TILT_COMPENSATED_COMPASS_ANGLES_UNIT_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_ANGLES_UNIT_MACROS_SVH

// condition holds in the same cycle
`define CEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compass unit assertion failed");

// condition holds in the next cycle
`define CEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compass unit assertion failed");

`endif

// ----- sv/cec_pkg.sv -----
// shared types, constants and helper functions of the compass angle unit
package cec_pkg;

  localparam int unsigned DEF_CORDIC_STAGES = 16;
  localparam int unsigned DEF_SAMPLE_BITS   = 16;
  localparam int unsigned MAX_STAGES        = 24;

  localparam int unsigned IN_W     = 16;
  localparam int unsigned DW       = 38;
  localparam int unsigned AW       = 34;
  localparam int unsigned RAD_W    = 62;
  localparam int unsigned SQ_CELLS = RAD_W / 2;
  localparam int unsigned ROOT_W   = 31;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned OUT_W    = 48;

  localparam logic signed [AW-1:0] HALF_TURN    = 34'sh0_8000_0000;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;

  // atan(2^-i), one full turn is 2^32
  localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } cv_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  typedef struct packed {
    cv_t                  v;
    logic                 forced;
    logic signed [AW-1:0] ang;
  } vpre_t;

  function automatic logic signed [AW-1:0] wrap32(input logic signed [AW-1:0] z);
    return AW'($signed(z[31:0]));
  endfunction

  // vectoring setup: axis cases give an exact angle, left half plane is folded
  function automatic vpre_t vec_pre(input logic signed [DW-1:0] y,
                                    input logic signed [DW-1:0] x);
    vpre_t r;
    r.v.x    = x;
    r.v.y    = y;
    r.v.z    = '0;
    r.forced = 1'b0;
    r.ang    = '0;
    if (y == 0) begin
      r.forced = 1'b1;
      r.ang    = (x < 0) ? HALF_TURN : '0;
    end else if (x == 0) begin
      r.forced = 1'b1;
      r.ang    = (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
    end else if (x < 0) begin
      r.v.z = (y > 0) ? HALF_TURN : -HALF_TURN;
      r.v.x = -x;
      r.v.y = -y;
    end
    return r;
  endfunction

  // rotation setup: bring the angle into the right half plane
  function automatic cv_t rot_pre(input logic signed [DW-1:0] x,
                                  input logic signed [DW-1:0] y,
                                  input logic signed [AW-1:0] th);
    cv_t r;
    logic signed [AW-1:0] z;
    z   = wrap32(th);
    r.x = x;
    r.y = y;
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      r.x = -x;
      r.y = -y;
      z   = wrap32(z + HALF_TURN);
    end
    r.z = z;
    return r;
  endfunction

  function automatic logic signed [AW-1:0] vec_ang(input logic forced,
                                                   input logic signed [AW-1:0] ang,
                                                   input logic signed [AW-1:0] z);
    return forced ? ang : wrap32(z);
  endfunction

endpackage

// ----- sv/tilt_compensated_compass_angles_unit.sv -----
// top level of the tilt-compensated compass angle unit
// usage:
//   slave stream: one transaction carries an accelerometer and a magnetometer
//   vector, six signed samples of 16 bits, read as SAMPLE_BITS-bit values
//   master stream: one transaction per input with yaw 0..35999, pitch
//   -9000..9000 and roll -18000..18000 in hundredths of a degree
// timing:
//   one transaction accepted per cycle, sustained while the skid entry is empty
//   the path from accept to m_axis_tvalid runs through the input stage,
//   31 root digit cells, four cordic rows of CORDIC_STAGES cells each behind
//   a setup register, one scaling multiply stage and the output register
// reset:
//   clears the valid flags of the pipeline and of the output stage only
// stall:
//   an output register plus one skid entry; input keeps flowing while one
//   result waits, the whole pipeline freezes only when the skid entry is full
module tilt_compensated_compass_angles_unit #(
  parameter int unsigned CORDIC_STAGES = cec_pkg::DEF_CORDIC_STAGES,
  parameter int unsigned SAMPLE_BITS   = cec_pkg::DEF_SAMPLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, 16 bits each
  input  logic [6*cec_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // yaw_centideg[15:0], pitch_centideg[30:16], roll_centideg[46:31], zero
  output logic [cec_pkg::OUT_W-1:0] m_axis_tdata
);
  import cec_pkg::*;

`include "tilt_compensated_compass_angles_unit_macros.svh"

  localparam int unsigned SW  = SAMPLE_BITS;
  localparam int unsigned FS  = 30 - SAMPLE_BITS;
  localparam int unsigned NS  = CORDIC_STAGES;
  localparam int unsigned GRP = NS + 1;
  localparam int unsigned LAT = 1 + SQ_CELLS + 4 * GRP + 1;

  typedef struct packed {
    logic signed [SW:0] ax;
    logic signed [SW:0] ay;
    logic signed [SW:0] azn;
    logic signed [SW:0] mx;
    logic signed [SW:0] my;
    logic signed [SW:0] mz;
  } smp_t;

  typedef struct packed {
    logic                 p_forced;
    logic signed [AW-1:0] p_ang;
    logic                 r_forced;
    logic signed [AW-1:0] r_ang;
    logic signed [SW:0]   mx;
    logic signed [SW:0]   mz;
  } c1_t;

  typedef struct packed {
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic signed [DW-1:0] wx;
  } c2_t;

  typedef struct packed {
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
  } c3_t;

  typedef struct packed {
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic                 y_forced;
    logic signed [AW-1:0] y_ang;
  } c4_t;

  function automatic logic signed [SW:0] take(input logic [IN_W-1:0] f);
    logic [IN_W+SW-1:0] w;
    w = (IN_W+SW)'(f);
    return (SW+1)'($signed(w[SW-1:0]));
  endfunction

  function automatic logic signed [DW-1:0] scl(input logic signed [SW:0] v);
    return DW'(v) <<< FS;
  endfunction

  // handshake and pipeline advance
  logic           en;
  logic           in_acc;
  logic [LAT-1:0] vld_q;
  logic           push;

  logic              out_valid_d, out_valid_q;
  logic              skid_valid_d, skid_valid_q;
  logic [OUT_W-1:0]  out_d, out_q;
  logic [OUT_W-1:0]  skid_d, skid_q;
  logic [OUT_W-1:0]  res;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push          = en && vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_acc};
    end
  end

  // input stage: sign extension and the squared tilt magnitude
  smp_t                  smp_d, smp_q, smp1;
  logic signed [2*SW+1:0] sq_sum;
  logic [RAD_W-1:0]      rad_d, rad_q;

  always_comb begin
    smp_d.ax  = take(s_axis_tdata[0*IN_W +: IN_W]);
    smp_d.ay  = take(s_axis_tdata[1*IN_W +: IN_W]);
    smp_d.azn = -take(s_axis_tdata[2*IN_W +: IN_W]);
    smp_d.mx  = take(s_axis_tdata[3*IN_W +: IN_W]);
    smp_d.my  = take(s_axis_tdata[4*IN_W +: IN_W]);
    smp_d.mz  = take(s_axis_tdata[5*IN_W +: IN_W]);
    sq_sum    = smp_d.ay * smp_d.ay + smp_d.azn * smp_d.azn;
    rad_d     = RAD_W'($unsigned(sq_sum)) << (2 * FS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      smp_q <= smp_d;
      rad_q <= rad_d;
    end
  end

  // square root row, one result bit per cell
  sq_t sq [SQ_CELLS+1];

  assign sq[0] = '{rem: '0, root: '0, rad: rad_q};

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    cec_sqrt_cell u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .s_i   (sq[k]),
      .s_o   (sq[k+1])
    );
  end

  cec_delay #(.WIDTH($bits(smp_t)), .DEPTH(SQ_CELLS)) u_dly_smp (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (smp_q),
    .d_o   (smp1)
  );

  // row 1: pitch and roll vectoring, my through a zero-angle rotation
  vpre_t p_pitch, p_roll;
  cv_t   p_w0;
  c1_t   c1_in, c1_out;
  cv_t   g1p_q, g1r_q, g1w_q;
  cv_t   r1p, r1r, r1w;

  always_comb begin
    p_pitch = vec_pre(-scl(smp1.ax), DW'(sq[SQ_CELLS].root));
    p_roll  = vec_pre(scl(smp1.ay), scl(smp1.azn));
    // level in y: roll is a half turn unless the raw z reading is negative
    if (smp1.ay == 0) begin
      p_roll.forced = 1'b1;
      p_roll.ang    = (smp1.azn <= 0) ? HALF_TURN : '0;
    end
    p_w0            = rot_pre(scl(smp1.my), '0, '0);
    c1_in.p_forced  = p_pitch.forced;
    c1_in.p_ang     = p_pitch.ang;
    c1_in.r_forced  = p_roll.forced;
    c1_in.r_ang     = p_roll.ang;
    c1_in.mx        = smp1.mx;
    c1_in.mz        = smp1.mz;
  end

  // row 2: magnetometer x/z rotated by pitch
  logic signed [AW-1:0] pitch_a, roll_a;
  cv_t                  p_u;
  c2_t                  c2_in, c2_out;
  cv_t                  g2u_q, r2u;

  always_comb begin
    pitch_a      = vec_ang(c1_out.p_forced, c1_out.p_ang, r1p.z);
    roll_a       = vec_ang(c1_out.r_forced, c1_out.r_ang, r1r.z);
    p_u          = rot_pre(scl(c1_out.mx), -scl(c1_out.mz), pitch_a);
    c2_in.pitch  = pitch_a;
    c2_in.roll   = roll_a;
    c2_in.wx     = r1w.x;
  end

  // row 3: horizontal y by roll, horizontal x gain-matched by a zero angle
  cv_t p_w, p_g;
  c3_t c3_in, c3_out;
  cv_t g3w_q, g3g_q, r3w, r3g;

  always_comb begin
    p_w         = rot_pre(c2_out.wx, -r2u.y, c2_out.roll);
    p_g         = rot_pre(r2u.x, '0, '0);
    c3_in.pitch = c2_out.pitch;
    c3_in.roll  = c2_out.roll;
  end

  // row 4: heading vectoring
  vpre_t p_yaw;
  c4_t   c4_in, c4_out;
  cv_t   g4y_q, r4y;

  always_comb begin
    p_yaw          = vec_pre(r3w.x, r3g.x);
    c4_in.pitch    = c3_out.pitch;
    c4_in.roll     = c3_out.roll;
    c4_in.y_forced = p_yaw.forced;
    c4_in.y_ang    = p_yaw.ang;
  end

  // setup registers in front of each cordic row
  always_ff @(posedge clk_i) begin
    if (en) begin
      g1p_q <= p_pitch.v;
      g1r_q <= p_roll.v;
      g1w_q <= p_w0;
      g2u_q <= p_u;
      g3w_q <= p_w;
      g3g_q <= p_g;
      g4y_q <= p_yaw.v;
    end
  end

  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b1)) u_row_pitch (
    .clk_i (clk_i), .en_i (en), .v_i (g1p_q), .v_o (r1p)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b1)) u_row_roll (
    .clk_i (clk_i), .en_i (en), .v_i (g1r_q), .v_o (r1r)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b0)) u_row_w0 (
    .clk_i (clk_i), .en_i (en), .v_i (g1w_q), .v_o (r1w)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b0)) u_row_u (
    .clk_i (clk_i), .en_i (en), .v_i (g2u_q), .v_o (r2u)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b0)) u_row_w (
    .clk_i (clk_i), .en_i (en), .v_i (g3w_q), .v_o (r3w)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b0)) u_row_g (
    .clk_i (clk_i), .en_i (en), .v_i (g3g_q), .v_o (r3g)
  );
  cec_cordic_chain #(.STAGES(NS), .VECTORING(1'b1)) u_row_yaw (
    .clk_i (clk_i), .en_i (en), .v_i (g4y_q), .v_o (r4y)
  );

  cec_delay #(.WIDTH($bits(c1_t)), .DEPTH(GRP)) u_dly_c1 (
    .clk_i (clk_i), .en_i (en), .d_i (c1_in), .d_o (c1_out)
  );
  cec_delay #(.WIDTH($bits(c2_t)), .DEPTH(GRP)) u_dly_c2 (
    .clk_i (clk_i), .en_i (en), .d_i (c2_in), .d_o (c2_out)
  );
  cec_delay #(.WIDTH($bits(c3_t)), .DEPTH(GRP)) u_dly_c3 (
    .clk_i (clk_i), .en_i (en), .d_i (c3_in), .d_o (c3_out)
  );
  cec_delay #(.WIDTH($bits(c4_t)), .DEPTH(GRP)) u_dly_c4 (
    .clk_i (clk_i), .en_i (en), .d_i (c4_in), .d_o (c4_out)
  );

  // binary angle to centidegrees: multiply by 36000, round at bit 32
  logic signed [AW-1:0] yaw_a;
  logic [48:0]          mul_yaw_d, mul_yaw_q;
  logic signed [51:0]   mul_pitch_d, mul_pitch_q;
  logic signed [51:0]   mul_roll_d, mul_roll_q;

  always_comb begin
    yaw_a       = vec_ang(c4_out.y_forced, c4_out.y_ang, r4y.z);
    mul_yaw_d   = 49'(yaw_a[31:0]) * 49'd36000 + 49'h0_8000_0000;
    mul_pitch_d = 52'(c4_out.pitch) * 52'sd36000 + 52'sh8000_0000;
    mul_roll_d  = 52'(c4_out.roll) * 52'sd36000 + 52'sh8000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_yaw_q   <= mul_yaw_d;
      mul_pitch_q <= mul_pitch_d;
      mul_roll_q  <= mul_roll_d;
    end
  end

  // wrap and clamp into the reported ranges
  logic [16:0]        yc_raw;
  logic [15:0]        yc;
  logic signed [19:0] pc_raw, rc_raw;
  logic signed [19:0] pc, rc;

  always_comb begin
    yc_raw = mul_yaw_q[48:32];
    yc     = (yc_raw >= 17'd36000) ? '0 : yc_raw[15:0];
    pc_raw = mul_pitch_q[51:32];
    rc_raw = mul_roll_q[51:32];
    pc     = pc_raw;
    if (pc_raw > 20'sd9000)  pc = 20'sd9000;
    if (pc_raw < -20'sd9000) pc = -20'sd9000;
    rc     = rc_raw;
    if (rc_raw > 20'sd18000)  rc = 20'sd18000;
    if (rc_raw < -20'sd18000) rc = -20'sd18000;
    res    = {1'b0, rc[15:0], pc[14:0], yc};
  end

  // output register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (en) begin
      if (push) begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res;
        end else begin
          skid_valid_d = 1'b1;
          skid_d       = res;
        end
      end else if (m_axis_tready) begin
        out_valid_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      // skid full: drain it into the output register
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `CEC_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `CEC_ASSERT_NXT(a_skid_holds, skid_valid_q && !m_axis_tready, skid_valid_q && $stable(skid_q))
  `CEC_ASSERT_IMP(a_yaw_range, out_valid_q, out_q[15:0] < 16'd36000)
  `CEC_ASSERT_IMP(a_pitch_range, out_valid_q, ($signed(out_q[30:16]) <= 15'sd9000) && ($signed(out_q[30:16]) >= -15'sd9000))

endmodule

// ----- sv/cec_sqrt_cell.sv -----
// one digit of the bit-serial square root chain
module cec_sqrt_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  cec_pkg::sq_t  s_i,
  output cec_pkg::sq_t  s_o
);
  import cec_pkg::*;

  sq_t              s_d, s_q;
  logic [REM_W-1:0] acc;
  logic [REM_W:0]   trial;

  always_comb begin
    acc   = {s_i.rem[REM_W-3:0], s_i.rad[RAD_W-1 -: 2]};
    trial = {1'b0, acc} - (REM_W+1)'({s_i.root, 2'b01});
    s_d.rad = {s_i.rad[RAD_W-3:0], 2'b00};
    if (!trial[REM_W]) begin
      s_d.rem  = trial[REM_W-1:0];
      s_d.root = {s_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      s_d.rem  = acc;
      s_d.root = {s_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

// ----- sv/cec_cordic_cell.sv -----
// one micro-rotation of a cordic chain
module cec_cordic_cell #(
  parameter int unsigned STAGE     = 0,
  parameter bit          VECTORING = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  cec_pkg::cv_t  v_i,
  output cec_pkg::cv_t  v_o
);
  import cec_pkg::*;

  localparam logic signed [AW-1:0] ATAN = AW'(ATAN_TAB[STAGE]);

  cv_t                  v_d, v_q;
  logic signed [DW-1:0] dx, dy;
  logic                 neg;

  always_comb begin
    dx  = v_i.y >>> STAGE;
    dy  = v_i.x >>> STAGE;
    neg = VECTORING ? (v_i.y < 0) : (v_i.z >= 0);
    if (neg) begin
      v_d.x = v_i.x - dx;
      v_d.y = v_i.y + dy;
      v_d.z = v_i.z - ATAN;
    end else begin
      v_d.x = v_i.x + dx;
      v_d.y = v_i.y - dy;
      v_d.z = v_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

// ----- sv/cec_cordic_chain.sv -----
// row of cordic cells, one stage per cell
module cec_cordic_chain #(
  parameter int unsigned STAGES    = cec_pkg::DEF_CORDIC_STAGES,
  parameter bit          VECTORING = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  cec_pkg::cv_t  v_i,
  output cec_pkg::cv_t  v_o
);
  import cec_pkg::*;

  cv_t link [STAGES+1];

  assign link[0] = v_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    cec_cordic_cell #(
      .STAGE     (k),
      .VECTORING (VECTORING)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .v_i   (link[k]),
      .v_o   (link[k+1])
    );
  end

  assign v_o = link[STAGES];

endmodule

// ----- sv/cec_delay.sv -----
// enabled shift line carrying side data alongside the cell rows
module cec_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign d_o = pipe_q[DEPTH-1];

endmodule

// ----- verif/tb_tilt_compensated_compass_angles_unit.sv -----
// testbench of the compass angle unit: streams sensor samples, predicts angles, checks results
module tb_tilt_compensated_compass_angles_unit;
  import cec_pkg::*;

  localparam int unsigned LATENCY    = 4 * DEF_CORDIC_STAGES + 37;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam longint      SCALE      = 64'sd1 << (30 - DEF_SAMPLE_BITS);
  localparam longint      HALF       = 64'sd2147483648;
  localparam longint      QUARTER    = 64'sd1073741824;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [6*IN_W-1:0]         s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_W-1:0]          m_axis_tdata;

  logic [6*IN_W-1:0] sample_q [$];
  logic [OUT_W-1:0]  angles_q [$];
  int  errors = 0;
  int  results_seen = 0;
  int  cycle_cnt = 0;
  int  idle_cnt = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  tilt_compensated_compass_angles_unit i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  function automatic longint turn_wrap(input longint z);
    return longint'($signed(z[31:0]));
  endfunction

  // vectoring cordic, angle of (x, y) in binary angle units
  function automatic longint heading_of(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? HALF : 0;
    if (x == 0) return (y > 0) ? QUARTER : -QUARTER;
    if (x < 0) begin
      z = (y > 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    return turn_wrap(z);
  endfunction

  // rotation cordic, result carries the cordic gain
  function automatic void spin(inout longint x, inout longint y, input longint th);
    longint z, dx, dy;
    z = turn_wrap(th);
    if (z > QUARTER || z < -QUARTER) begin
      x = -x;
      y = -y;
      z = turn_wrap(z + HALF);
    end
    for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
  endfunction

  function automatic longint floor_root(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // yaw, pitch and roll packed as the master stream carries them
  function automatic logic [OUT_W-1:0] compass_angles(input logic [6*IN_W-1:0] d);
    longint ax, ay, az, mx, my, mz, azn, r, pitch, roll, yaw;
    longint ux, uy, wx, wy, gx, gy, pc, rc, yc;
    longint unsigned yu;
    logic [OUT_W-1:0] o;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    mx = longint'($signed(d[63:48]));
    my = longint'($signed(d[79:64]));
    mz = longint'($signed(d[95:80]));
    azn = -az;
    r = floor_root(longint'(ay * ay + azn * azn) << (2 * (30 - DEF_SAMPLE_BITS)));
    pitch = heading_of(-ax * SCALE, r);
    if (ay == 0) roll = (az >= 0) ? HALF : 0;
    else roll = heading_of(ay * SCALE, azn * SCALE);
    ux = mx * SCALE;
    uy = -mz * SCALE;
    spin(ux, uy, pitch);
    // gain matching: terms without a gain pass through a zero rotation
    wx = my * SCALE;
    wy = 0;
    spin(wx, wy, 0);
    wy = -uy;
    spin(wx, wy, roll);
    gx = ux;
    gy = 0;
    spin(gx, gy, 0);
    yaw = heading_of(wx, gx);
    yu = longint'(yaw[31:0]) & 64'hFFFF_FFFF;
    yc = longint'((yu * 36000 + 64'd2147483648) >> 32);
    if (yc >= 36000) yc = 0;
    pc = (pitch * 36000 + HALF) >>> 32;
    if (pc > 9000) pc = 9000;
    if (pc < -9000) pc = -9000;
    rc = (roll * 36000 + HALF) >>> 32;
    if (rc > 18000) rc = 18000;
    if (rc < -18000) rc = -18000;
    o = '0;
    o[15:0]  = yc[15:0];
    o[30:16] = pc[14:0];
    o[46:31] = rc[15:0];
    return o;
  endfunction

  function automatic logic [15:0] random_axis();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
      2:       return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_sample(input logic [15:0] ax, ay, az, mx, my, mz);
    sample_q.push_back({mz, my, mx, az, ay, ax});
  endtask

  task automatic report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() > 0) begin
        s_axis_tdata  <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern rotates through always, mostly and half ready phases, one long hold-off
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 200) begin
        m_axis_tready <= 1'b0;
        hold_left <= 3 * LATENCY;
        hold_done <= 1'b1;
      end else begin
        case ((cycle_cnt / 400) % 3)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(3) != 0);
          default: m_axis_tready <= ($urandom_range(1) != 0);
        endcase
      end
    end
  end

  // predict on every input transaction, check every output transaction
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) angles_q.push_back(compass_angles(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (angles_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = angles_q.pop_front();
          report_field("yaw", want[15:0], m_axis_tdata[15:0]);
          report_field("pitch", $signed(want[30:16]), $signed(m_axis_tdata[30:16]));
          report_field("roll", $signed(want[46:31]), $signed(m_axis_tdata[46:31]));
          report_field("pad", want[47], m_axis_tdata[47]);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: axis cases, extremes, roll and pitch corners
    add_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h0000, 16'hF000, 16'h1000, 16'h0800, 16'h0000);
    add_sample(16'h8000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
    add_sample(16'h7FFF, 16'h0000, 16'h0000, 16'hF000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
    add_sample(16'h0000, 16'hF000, 16'h0000, 16'h0000, 16'hF000, 16'h0000);
    add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_sample(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
    add_sample(16'h0000, 16'h0000, 16'hC000, 16'h1000, 16'hFFFF, 16'h0000);
    add_sample(16'h0000, 16'h0000, 16'hC000, 16'h1000, 16'h0001, 16'h0000);
    add_sample(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h7FFF);
    add_sample(16'h0000, 16'h0001, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'hFFFF, 16'h4000, 16'hFFFF, 16'h0000, 16'h0000);
    add_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    add_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    // sender pause until every expected result is back
    wait (sample_q.size() == 0 && !s_axis_tvalid && angles_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    for (int n = 0; n < 900; n++)
      add_sample(random_axis(), random_axis(), random_axis(),
                 random_axis(), random_axis(), random_axis());
    wait (sample_q.size() == 0 && !s_axis_tvalid && angles_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && angles_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cec_pkg.sv
sv/cec_sqrt_cell.sv
sv/cec_cordic_cell.sv
sv/cec_cordic_chain.sv
sv/cec_delay.sv
sv/tilt_compensated_compass_angles_unit.sv
verif/tb_tilt_compensated_compass_angles_unit.sv
